@@ hdl/line_follow_pd_steering_core_assert.svh @@
`ifndef LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH
`define LINE_FOLLOW_PD_STEERING_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LFPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lfps_pkg.sv @@
`timescale 1ns / 1ps

package lfps_pkg;

  // default datapath sizes
  localparam int ERROR_WIDTH = 10;
  localparam int COUNT_WIDTH = 8;

  // fixed field widths
  localparam int GAIN_WIDTH     = 16;
  localparam int SPEED_WIDTH    = 9;
  localparam int DEB_WIDTH      = 8;
  localparam int MAG_WIDTH      = 9;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int FRAC_BITS      = 8;

  // wheel drive limits
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = -9'sd50;
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = 9'sd255;

  // register reset values
  localparam logic [GAIN_WIDTH-1:0]         PROP_GAIN_RST  = 16'd128;
  localparam logic [GAIN_WIDTH-1:0]         DERIV_GAIN_RST = 16'd64;
  localparam logic signed [SPEED_WIDTH-1:0] BASE_SPEED_RST = 9'sd150;
  localparam logic [DEB_WIDTH-1:0]          DEBOUNCE_RST   = 8'd3;
  localparam logic [MAG_WIDTH-1:0]          TURN_BIAS_RST  = 9'd100;
  localparam logic [MAG_WIDTH-1:0]          MAX_OFFSET_RST = 9'd160;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_DERIV_GAIN      = 3'd1,
    CFG_BASE_SPEED      = 3'd2,
    CFG_DEBOUNCE_FRAMES = 3'd3,
    CFG_TURN_BIAS       = 3'd4,
    CFG_MAX_OFFSET      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MARKER_NONE  = 2'd0,
    MARKER_LEFT  = 2'd1,
    MARKER_RIGHT = 2'd2,
    MARKER_UTURN = 2'd3
  } marker_e;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]         prop_gain;
    logic [GAIN_WIDTH-1:0]         deriv_gain;
    logic signed [SPEED_WIDTH-1:0] base_speed;
    logic [DEB_WIDTH-1:0]          debounce_frames;
    logic [MAG_WIDTH-1:0]          turn_bias;
    logic [MAG_WIDTH-1:0]          max_offset;
  } cfg_t;

endpackage

@@ hdl/lfps_if.sv @@
`timescale 1ns / 1ps

// frame item channel
interface lfps_frame_if #(
  parameter int ERROR_WIDTH = lfps_pkg::ERROR_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          tracing_active;
  logic signed [ERROR_WIDTH-1:0] pixel_error;
  logic [1:0]                    marker_code;

  modport source (output valid, tracing_active, pixel_error, marker_code, input ready);
  modport sink   (input valid, tracing_active, pixel_error, marker_code, output ready);
endinterface

// wheel speed result channel
interface lfps_speed_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lfps_pkg::SPEED_WIDTH-1:0] left_speed;
  logic signed [lfps_pkg::SPEED_WIDTH-1:0] right_speed;

  modport source (output valid, left_speed, right_speed, input ready);
  modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

// register write channel
interface lfps_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lfps_pkg::CFG_IDX_WIDTH-1:0]  index;
  logic [lfps_pkg::CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/lfps_cfg.sv @@
`timescale 1ns / 1ps

module lfps_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfps_cfg_if.sink       cfg_i,
  output lfps_pkg::cfg_t cfg_o
);

  lfps_pkg::cfg_t cfg_q, cfg_d;

  // writes are always accepted, ready is tied high
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // register decode, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (lfps_pkg::cfg_idx_e'(cfg_i.index))
        lfps_pkg::CFG_PROP_GAIN:       cfg_d.prop_gain  = cfg_i.data;
        lfps_pkg::CFG_DERIV_GAIN:      cfg_d.deriv_gain = cfg_i.data;
        lfps_pkg::CFG_BASE_SPEED:
          cfg_d.base_speed = $signed(cfg_i.data[lfps_pkg::SPEED_WIDTH-1:0]);
        lfps_pkg::CFG_DEBOUNCE_FRAMES:
          cfg_d.debounce_frames = cfg_i.data[lfps_pkg::DEB_WIDTH-1:0];
        lfps_pkg::CFG_TURN_BIAS:  cfg_d.turn_bias  = cfg_i.data[lfps_pkg::MAG_WIDTH-1:0];
        lfps_pkg::CFG_MAX_OFFSET: cfg_d.max_offset = cfg_i.data[lfps_pkg::MAG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= lfps_pkg::PROP_GAIN_RST;
      cfg_q.deriv_gain      <= lfps_pkg::DERIV_GAIN_RST;
      cfg_q.base_speed      <= lfps_pkg::BASE_SPEED_RST;
      cfg_q.debounce_frames <= lfps_pkg::DEBOUNCE_RST;
      cfg_q.turn_bias       <= lfps_pkg::TURN_BIAS_RST;
      cfg_q.max_offset      <= lfps_pkg::MAX_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/lfps_err.sv @@
`timescale 1ns / 1ps

`include "line_follow_pd_steering_core_assert.svh"

module lfps_err #(
  parameter int ERROR_WIDTH = lfps_pkg::ERROR_WIDTH,
  parameter int COUNT_WIDTH = lfps_pkg::COUNT_WIDTH
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  lfps_frame_if.sink                                          frame_i,
  input  lfps_pkg::cfg_t                                      cfg_i,
  output logic                                                prod_valid_o,
  input  logic                                                prod_ready_i,
  output logic                                                prod_trace_o,
  output logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH:0]    prop_term_o,
  output logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH+1:0]  deriv_term_o
);

  localparam int CmpW = (COUNT_WIDTH > lfps_pkg::DEB_WIDTH) ? COUNT_WIDTH : lfps_pkg::DEB_WIDTH;
  localparam int LimW = (ERROR_WIDTH > lfps_pkg::MAG_WIDTH) ? ERROR_WIDTH : lfps_pkg::MAG_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [LimW-1:0] ErrLimit = LimW'((1 << (ERROR_WIDTH - 1)) - 1);

  // input register
  logic                          s0_v_q, s0_v_d;
  logic                          s0_trace_q;
  logic signed [ERROR_WIDTH-1:0] s0_err_q;
  logic [1:0]                    s0_code_q;
  logic                          s0_ready, s0_move;

  // product register
  logic                                                s1_v_q, s1_v_d;
  logic                                                s1_trace_q;
  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH:0]    prop_q, prop_d;
  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH+1:0]  deriv_q, deriv_d;
  logic                                                s1_ready;

  // steering state
  logic [COUNT_WIDTH-1:0]        left_frames_q, left_frames_d;
  logic [COUNT_WIDTH-1:0]        right_frames_q, right_frames_d;
  logic signed [ERROR_WIDTH-1:0] active_bias_q, active_bias_d;
  logic signed [ERROR_WIDTH-1:0] prev_error_q, prev_error_d;

  // per-item working values
  logic [lfps_pkg::DEB_WIDTH-1:0] thresh;
  logic [LimW-1:0]                mag_w, lim_w;
  logic signed [ERROR_WIDTH-1:0]  bias_mag, limit;
  logic [COUNT_WIDTH-1:0]         left_inc, right_inc, left_nx, right_nx;
  logic signed [ERROR_WIDTH-1:0]  bias_nx, err_c;
  logic signed [ERROR_WIDTH:0]    biased, lim_ext, diff;

  // handshake through the two register stages
  assign s1_ready      = !s1_v_q || prod_ready_i;
  assign s0_ready      = !s0_v_q || s1_ready;
  assign s0_move       = s0_v_q && s1_ready;
  assign frame_i.ready = s0_ready;
  assign s0_v_d        = s0_ready ? frame_i.valid : s0_v_q;
  assign s1_v_d        = s1_ready ? s0_v_q : s1_v_q;

  // limits derived from the registers
  assign thresh   = (cfg_i.debounce_frames == '0) ? lfps_pkg::DEB_WIDTH'(1)
                                                 : cfg_i.debounce_frames;
  assign mag_w    = (LimW'(cfg_i.turn_bias) > ErrLimit) ? ErrLimit : LimW'(cfg_i.turn_bias);
  assign lim_w    = (LimW'(cfg_i.max_offset) > ErrLimit) ? ErrLimit : LimW'(cfg_i.max_offset);
  assign bias_mag = $signed(mag_w[ERROR_WIDTH-1:0]);
  assign limit    = $signed(lim_w[ERROR_WIDTH-1:0]);

  // saturating frame counters
  assign left_inc  = (left_frames_q == CountMax) ? left_frames_q
                                                 : left_frames_q + COUNT_WIDTH'(1);
  assign right_inc = (right_frames_q == CountMax) ? right_frames_q
                                                  : right_frames_q + COUNT_WIDTH'(1);

  // marker debounce and turn bias
  always_comb begin
    left_nx  = '0;
    right_nx = '0;
    bias_nx  = active_bias_q;
    unique case (lfps_pkg::marker_e'(s0_code_q))
      lfps_pkg::MARKER_LEFT:  left_nx  = left_inc;
      lfps_pkg::MARKER_RIGHT: right_nx = right_inc;
      lfps_pkg::MARKER_NONE,
      lfps_pkg::MARKER_UTURN: bias_nx  = '0;
    endcase
    priority if (CmpW'(left_nx) >= CmpW'(thresh)) begin
      bias_nx = -bias_mag;
    end else if (CmpW'(right_nx) >= CmpW'(thresh)) begin
      bias_nx = bias_mag;
    end else begin
      bias_nx = bias_nx;
    end
  end

  // biased error, clamped to the offset limit
  assign biased  = $signed({s0_err_q[ERROR_WIDTH-1], s0_err_q})
                 + $signed({bias_nx[ERROR_WIDTH-1], bias_nx});
  assign lim_ext = $signed({1'b0, limit});

  always_comb begin
    priority if (biased > lim_ext) begin
      err_c = limit;
    end else if (biased < -lim_ext) begin
      err_c = -limit;
    end else begin
      err_c = biased[ERROR_WIDTH-1:0];
    end
  end

  // proportional and derivative terms
  assign diff    = $signed({err_c[ERROR_WIDTH-1], err_c})
                 - $signed({prev_error_q[ERROR_WIDTH-1], prev_error_q});
  assign prop_d  = $signed({1'b0, cfg_i.prop_gain}) * err_c;
  assign deriv_d = $signed({1'b0, cfg_i.deriv_gain}) * diff;

  // state moves only on a tracing item
  always_comb begin
    left_frames_d  = left_frames_q;
    right_frames_d = right_frames_q;
    active_bias_d  = active_bias_q;
    prev_error_d   = prev_error_q;
    if (s0_move && s0_trace_q) begin
      left_frames_d  = left_nx;
      right_frames_d = right_nx;
      active_bias_d  = bias_nx;
      prev_error_d   = err_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q         <= 1'b0;
      s1_v_q         <= 1'b0;
      left_frames_q  <= '0;
      right_frames_q <= '0;
      active_bias_q  <= '0;
      prev_error_q   <= '0;
    end else begin
      s0_v_q         <= s0_v_d;
      s1_v_q         <= s1_v_d;
      left_frames_q  <= left_frames_d;
      right_frames_q <= right_frames_d;
      active_bias_q  <= active_bias_d;
      prev_error_q   <= prev_error_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (frame_i.valid && s0_ready) begin
      s0_trace_q <= frame_i.tracing_active;
      s0_err_q   <= frame_i.pixel_error;
      s0_code_q  <= frame_i.marker_code;
    end
    if (s0_move) begin
      s1_trace_q <= s0_trace_q;
      prop_q     <= prop_d;
      deriv_q    <= deriv_d;
    end
  end

  assign prod_valid_o = s1_v_q;
  assign prod_trace_o = s1_trace_q;
  assign prop_term_o  = prop_q;
  assign deriv_term_o = deriv_q;

  // checks
  `LFPS_ASSERT_NEXT(a_idle_item_keeps_state, s0_move && !s0_trace_q,
    $stable(left_frames_q) && $stable(right_frames_q) && $stable(active_bias_q)
    && $stable(prev_error_q), "non-tracing item changed steering state")
  `LFPS_ASSERT_IMPL(a_one_counter_running, 1'b1,
    left_frames_q == '0 || right_frames_q == '0, "both marker counters nonzero")

endmodule

@@ hdl/lfps_speed.sv @@
`timescale 1ns / 1ps

`include "line_follow_pd_steering_core_assert.svh"

module lfps_speed #(
  parameter int ERROR_WIDTH = lfps_pkg::ERROR_WIDTH
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               prod_valid_i,
  output logic                                               prod_ready_o,
  input  logic                                               prod_trace_i,
  input  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH:0]   prop_term_i,
  input  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH+1:0] deriv_term_i,
  input  lfps_pkg::cfg_t                                     cfg_i,
  lfps_speed_if.source                                       speed_o
);

  localparam int SumW  = ERROR_WIDTH + lfps_pkg::GAIN_WIDTH + 3;
  localparam int CorrW = SumW - lfps_pkg::FRAC_BITS;
  localparam int SpdW  = CorrW + 1;
  localparam int SW    = lfps_pkg::SPEED_WIDTH;

  logic                 out_v_q, out_v_d;
  logic signed [SW-1:0] left_q, left_d;
  logic signed [SW-1:0] right_q, right_d;

  logic signed [SumW-1:0]  p_sum, p_adj;
  logic signed [CorrW-1:0] corr;
  logic signed [SpdW-1:0]  base_ext, left_raw, right_raw;

  // pd sum, then divide by 256 rounding toward zero
  assign p_sum = SumW'(prop_term_i) + SumW'(deriv_term_i);
  assign p_adj = p_sum[SumW-1] ? p_sum + SumW'((1 << lfps_pkg::FRAC_BITS) - 1) : p_sum;
  assign corr  = $signed(p_adj[SumW-1:lfps_pkg::FRAC_BITS]);

  // differential drive around the base speed
  assign base_ext  = SpdW'(cfg_i.base_speed);
  assign left_raw  = base_ext + SpdW'(corr);
  assign right_raw = base_ext - SpdW'(corr);

  // clamp to the drive range, zero when not tracing
  always_comb begin
    priority if (!prod_trace_i) begin
      left_d = '0;
    end else if (left_raw < SpdW'(lfps_pkg::SPEED_MIN)) begin
      left_d = lfps_pkg::SPEED_MIN;
    end else if (left_raw > SpdW'(lfps_pkg::SPEED_MAX)) begin
      left_d = lfps_pkg::SPEED_MAX;
    end else begin
      left_d = left_raw[SW-1:0];
    end
  end

  always_comb begin
    priority if (!prod_trace_i) begin
      right_d = '0;
    end else if (right_raw < SpdW'(lfps_pkg::SPEED_MIN)) begin
      right_d = lfps_pkg::SPEED_MIN;
    end else if (right_raw > SpdW'(lfps_pkg::SPEED_MAX)) begin
      right_d = lfps_pkg::SPEED_MAX;
    end else begin
      right_d = right_raw[SW-1:0];
    end
  end

  // output register
  assign prod_ready_o = !out_v_q || speed_o.ready;
  assign out_v_d      = prod_ready_o ? prod_valid_i : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_i && prod_ready_o) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign speed_o.valid       = out_v_q;
  assign speed_o.left_speed  = left_q;
  assign speed_o.right_speed = right_q;

  // checks
  `LFPS_ASSERT_NEXT(a_idle_gives_zero, prod_valid_i && prod_ready_o && !prod_trace_i,
    left_q == '0 && right_q == '0, "non-tracing transaction gave nonzero speed")
  `LFPS_ASSERT_IMPL(a_speed_in_range, out_v_q,
    left_q >= lfps_pkg::SPEED_MIN && left_q <= lfps_pkg::SPEED_MAX
    && right_q >= lfps_pkg::SPEED_MIN && right_q <= lfps_pkg::SPEED_MAX,
    "wheel speed outside drive range")

endmodule

@@ hdl/line_follow_pd_steering_core.sv @@
`timescale 1ns / 1ps
// path: a frame transaction reaches speed valid through the input, product and output registers
// throughput: one frame per cycle while the speed channel does not stall, set by the state update in the error stage
// stalls on the speed channel back up through the stages without losing a transaction
// reset: control and steering state cleared, registers loaded with their default values
// register writes complete in the cycle they are presented

module line_follow_pd_steering_core #(
  parameter int ERROR_WIDTH = lfps_pkg::ERROR_WIDTH,
  parameter int COUNT_WIDTH = lfps_pkg::COUNT_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfps_frame_if.sink   frame_i,
  lfps_cfg_if.sink     cfg_i,
  lfps_speed_if.source speed_o
);

  lfps_pkg::cfg_t cfg;

  logic                                                prod_valid;
  logic                                                prod_ready;
  logic                                                prod_trace;
  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH:0]    prop_term;
  logic signed [ERROR_WIDTH+lfps_pkg::GAIN_WIDTH+1:0]  deriv_term;

  // register file
  lfps_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // debounce, bias, clamp and gain products
  lfps_err #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_err (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame_i),
    .cfg_i        (cfg),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_trace_o (prod_trace),
    .prop_term_o  (prop_term),
    .deriv_term_o (deriv_term)
  );

  // correction and wheel speeds
  lfps_speed #(
    .ERROR_WIDTH (ERROR_WIDTH)
  ) u_speed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_trace_i (prod_trace),
    .prop_term_i  (prop_term),
    .deriv_term_i (deriv_term),
    .cfg_i        (cfg),
    .speed_o      (speed_o)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef logic signed [lfps_pkg::ERROR_WIDTH-1:0] err_t;
  typedef logic signed [lfps_pkg::SPEED_WIDTH-1:0] spd_t;
  typedef logic [lfps_pkg::COUNT_WIDTH-1:0]        cnt_t;

  typedef struct {
    spd_t left_speed;
    spd_t right_speed;
  } wheel_pair_t;

  localparam longint ERR_LIMIT    = (longint'(1) << (lfps_pkg::ERROR_WIDTH - 1)) - 1;
  localparam err_t   ERR_MAX      = err_t'(ERR_LIMIT);
  localparam err_t   ERR_MIN      = err_t'(-ERR_LIMIT - 1);
  localparam cnt_t   COUNT_MAX    = '1;
  localparam int     CFG_IDX_LAST = (1 << lfps_pkg::CFG_IDX_WIDTH) - 1;
  localparam int     MAX_GAP      = 9;
  localparam int     DRAIN_CYCLES = 6;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     PHASE_ITEMS  = 100;

  // steering predictor and queue of expected wheel speeds
  class wheel_speed_scoreboard;
    lfps_pkg::cfg_t regs;
    cnt_t           left_frames;
    cnt_t           right_frames;
    err_t           active_bias;
    err_t           last_error;
    wheel_pair_t    expected_speeds[$];
    int             checked;
    int             failures;

    function new();
      regs.prop_gain       = lfps_pkg::PROP_GAIN_RST;
      regs.deriv_gain      = lfps_pkg::DERIV_GAIN_RST;
      regs.base_speed      = lfps_pkg::BASE_SPEED_RST;
      regs.debounce_frames = lfps_pkg::DEBOUNCE_RST;
      regs.turn_bias       = lfps_pkg::TURN_BIAS_RST;
      regs.max_offset      = lfps_pkg::MAX_OFFSET_RST;
      left_frames  = '0;
      right_frames = '0;
      active_bias  = '0;
      last_error   = '0;
      checked      = 0;
      failures     = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(logic [lfps_pkg::CFG_IDX_WIDTH-1:0] idx,
                            logic [lfps_pkg::CFG_DATA_WIDTH-1:0] data);
      case (idx)
        lfps_pkg::CFG_PROP_GAIN:  regs.prop_gain  = data;
        lfps_pkg::CFG_DERIV_GAIN: regs.deriv_gain = data;
        lfps_pkg::CFG_BASE_SPEED:
          regs.base_speed = data[lfps_pkg::SPEED_WIDTH-1:0];
        lfps_pkg::CFG_DEBOUNCE_FRAMES:
          regs.debounce_frames = data[lfps_pkg::DEB_WIDTH-1:0];
        lfps_pkg::CFG_TURN_BIAS:  regs.turn_bias  = data[lfps_pkg::MAG_WIDTH-1:0];
        lfps_pkg::CFG_MAX_OFFSET: regs.max_offset = data[lfps_pkg::MAG_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // predict the speeds for one accepted frame and, for a tracing frame, advance the steering state
    function void note_frame(logic tracing, err_t pixel_err, logic [1:0] marker);
      wheel_pair_t res;
      int unsigned thresh;
      longint      bias_mag, lim, e, p, corr, base;
      thresh = (regs.debounce_frames == 0) ? 1 : regs.debounce_frames;
      if (!tracing) begin
        res.left_speed  = '0;
        res.right_speed = '0;
        expected_speeds.push_back(res);
        return;
      end
      // marker debounce with saturating counters
      case (marker)
        lfps_pkg::MARKER_LEFT: begin
          if (left_frames != COUNT_MAX) left_frames++;
          right_frames = '0;
        end
        lfps_pkg::MARKER_RIGHT: begin
          if (right_frames != COUNT_MAX) right_frames++;
          left_frames = '0;
        end
        default: begin
          left_frames  = '0;
          right_frames = '0;
          active_bias  = '0;
        end
      endcase
      bias_mag = clip(longint'(regs.turn_bias), 0, ERR_LIMIT);
      if (left_frames >= thresh) active_bias = err_t'(-bias_mag);
      else if (right_frames >= thresh) active_bias = err_t'(bias_mag);
      // biased and clamped error, then pd correction truncated toward zero
      lim  = clip(longint'(regs.max_offset), 0, ERR_LIMIT);
      e    = clip(longint'(pixel_err) + longint'(active_bias), -lim, lim);
      p    = longint'(regs.prop_gain) * e
           + longint'(regs.deriv_gain) * (e - longint'(last_error));
      corr = p / 256;
      last_error = err_t'(e);
      base = longint'($signed(regs.base_speed));
      res.left_speed  = spd_t'(clip(base + corr, longint'(lfps_pkg::SPEED_MIN),
                                    longint'(lfps_pkg::SPEED_MAX)));
      res.right_speed = spd_t'(clip(base - corr, longint'(lfps_pkg::SPEED_MIN),
                                    longint'(lfps_pkg::SPEED_MAX)));
      expected_speeds.push_back(res);
    endfunction

    function void report(string what, longint want, longint got);
      failures++;
      if (failures <= 10)
        $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // compare one speed transaction with the oldest prediction
    function void check_speed(spd_t left_got, spd_t right_got);
      wheel_pair_t want;
      checked++;
      if (expected_speeds.size() == 0) begin
        report("unexpected speed transaction, left_speed", 0, left_got);
        return;
      end
      want = expected_speeds.pop_front();
      if (left_got !== want.left_speed) report("left_speed", want.left_speed, left_got);
      if (right_got !== want.right_speed) report("right_speed", want.right_speed, right_got);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   frame_gaps;
  bit   speed_gaps;
  bit   hold_go;
  bit   hold_active;
  int   frames_sent;
  int   settings_used;

  wheel_speed_scoreboard sb;

  lfps_frame_if frame_ch ();
  lfps_cfg_if   cfg_ch ();
  lfps_speed_if speed_ch ();

  line_follow_pd_steering_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_ch),
    .cfg_i   (cfg_ch),
    .speed_o (speed_ch)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // cycle watchdog
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles", cyc);
    $display("CHECK FAILED");
    $finish;
  end

  // long receiver hold-off, counted on the falling edge
  initial begin : speed_hold
    hold_active = 1'b0;
    wait (hold_go);
    @(negedge clk_i);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_active = 1'b0;
  end

  // speed receiver with random stalls
  initial begin : speed_sink
    int wait_left;
    wait_left = 0;
    speed_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && speed_ch.valid && speed_ch.ready) begin
        sb.check_speed(speed_ch.left_speed, speed_ch.right_speed);
        wait_left = speed_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end else if (wait_left > 0 && !hold_active) begin
        wait_left--;
      end
      speed_ch.ready <= rst_ni && (wait_left == 0) && !hold_active;
    end
  end

  // one frame transaction; valid stays high after acceptance
  task automatic send_frame(input logic tracing, input err_t pixel_err,
                            input lfps_pkg::marker_e marker);
    int gap;
    gap = frame_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_ch.valid          <= 1'b1;
    frame_ch.tracing_active <= tracing;
    frame_ch.pixel_error    <= pixel_err;
    frame_ch.marker_code    <= marker;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    sb.note_frame(tracing, pixel_err, marker);
    frames_sent++;
  endtask

  // one register write; valid stays high after acceptance
  task automatic cfg_write(input logic [lfps_pkg::CFG_IDX_WIDTH-1:0] idx,
                           input logic [lfps_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // wait until every predicted result has arrived and the pipe is empty
  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    while (sb.expected_speeds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // load all registers, with junk in unused data bits and a write to a spare index
  task automatic program_regs(input lfps_pkg::cfg_t c);
    logic [lfps_pkg::CFG_DATA_WIDTH-1:0] d;
    drain_results();
    cfg_write(lfps_pkg::CFG_IDX_WIDTH'($urandom_range(lfps_pkg::CFG_MAX_OFFSET + 1,
                                                      CFG_IDX_LAST)),
              lfps_pkg::CFG_DATA_WIDTH'($urandom));
    cfg_write(lfps_pkg::CFG_PROP_GAIN, c.prop_gain);
    cfg_write(lfps_pkg::CFG_DERIV_GAIN, c.deriv_gain);
    d = lfps_pkg::CFG_DATA_WIDTH'($urandom);
    d[lfps_pkg::SPEED_WIDTH-1:0] = c.base_speed;
    cfg_write(lfps_pkg::CFG_BASE_SPEED, d);
    d = lfps_pkg::CFG_DATA_WIDTH'($urandom);
    d[lfps_pkg::DEB_WIDTH-1:0] = c.debounce_frames;
    cfg_write(lfps_pkg::CFG_DEBOUNCE_FRAMES, d);
    d = lfps_pkg::CFG_DATA_WIDTH'($urandom);
    d[lfps_pkg::MAG_WIDTH-1:0] = c.turn_bias;
    cfg_write(lfps_pkg::CFG_TURN_BIAS, d);
    d = lfps_pkg::CFG_DATA_WIDTH'($urandom);
    d[lfps_pkg::MAG_WIDTH-1:0] = c.max_offset;
    cfg_write(lfps_pkg::CFG_MAX_OFFSET, d);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic err_t draw_error();
    case ($urandom_range(0, 9))
      0:       return ERR_MAX;
      1:       return ERR_MIN;
      2, 3:    return err_t'(int'($urandom_range(0, 40)) - 20);
      default: return err_t'($urandom);
    endcase
  endfunction

  function automatic lfps_pkg::marker_e draw_marker();
    case ($urandom_range(0, 9))
      0, 1, 2: return lfps_pkg::MARKER_LEFT;
      3, 4, 5: return lfps_pkg::MARKER_RIGHT;
      6, 7:    return lfps_pkg::MARKER_NONE;
      default: return lfps_pkg::MARKER_UTURN;
    endcase
  endfunction

  function automatic lfps_pkg::cfg_t draw_cfg();
    lfps_pkg::cfg_t c;
    c.prop_gain  = $urandom_range(0, 1) ? lfps_pkg::GAIN_WIDTH'($urandom_range(0, 1024))
                                        : lfps_pkg::GAIN_WIDTH'($urandom);
    c.deriv_gain = $urandom_range(0, 1) ? lfps_pkg::GAIN_WIDTH'($urandom_range(0, 1024))
                                        : lfps_pkg::GAIN_WIDTH'($urandom);
    c.base_speed = ($urandom_range(0, 4) < 3) ? spd_t'(int'($urandom_range(0, 305)) - 50)
                                              : spd_t'($urandom);
    c.debounce_frames = ($urandom_range(0, 9) < 7)
                      ? lfps_pkg::DEB_WIDTH'($urandom_range(0, 6))
                      : lfps_pkg::DEB_WIDTH'($urandom);
    c.turn_bias  = $urandom_range(0, 1) ? lfps_pkg::MAG_WIDTH'($urandom_range(0, 200))
                                        : lfps_pkg::MAG_WIDTH'($urandom);
    c.max_offset = $urandom_range(0, 1) ? lfps_pkg::MAG_WIDTH'($urandom_range(0, 200))
                                        : lfps_pkg::MAG_WIDTH'($urandom);
    return c;
  endfunction

  // marker run: mostly tracing frames, with an occasional idle frame inside
  task automatic send_run(input lfps_pkg::marker_e marker, input int len);
    for (int i = 0; i < len; i++)
      send_frame($urandom_range(0, 19) != 0, draw_error(), marker);
  endtask

  // random marker runs sized around the debounce threshold, plus noise frames
  task automatic run_random_frames(input int n_items);
    int left, thr, len;
    left = n_items;
    thr  = (sb.regs.debounce_frames > 12) ? 12 : sb.regs.debounce_frames;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_frame(1'b0, draw_error(), lfps_pkg::marker_e'($urandom_range(0, 3)));
        left--;
      end else begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, thr + 3) : $urandom_range(1, 3);
        if (len > left) len = left;
        send_run(draw_marker(), len);
        left -= len;
      end
    end
  endtask

  initial begin : stimulus
    lfps_pkg::cfg_t c;
    frame_ch.valid          = 1'b0;
    frame_ch.tracing_active = 1'b0;
    frame_ch.pixel_error    = '0;
    frame_ch.marker_code    = lfps_pkg::MARKER_NONE;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = lfps_pkg::CFG_PROP_GAIN;
    cfg_ch.data             = '0;
    rst_ni                  = 1'b0;
    hold_go                 = 1'b0;
    frames_sent             = 0;
    settings_used           = 1;
    frame_gaps              = 1'b1;
    speed_gaps              = 1'b1;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the reset settings
    send_frame(1'b0, ERR_MAX, lfps_pkg::MARKER_LEFT);
    send_frame(1'b0, ERR_MIN, lfps_pkg::MARKER_RIGHT);
    send_frame(1'b1, '0, lfps_pkg::MARKER_NONE);
    send_frame(1'b1, ERR_MAX, lfps_pkg::MARKER_NONE);
    send_frame(1'b1, ERR_MIN, lfps_pkg::MARKER_NONE);
    send_run(lfps_pkg::MARKER_LEFT, 0);
    for (int i = 0; i < 3; i++) send_frame(1'b1, '0, lfps_pkg::MARKER_LEFT);
    send_frame(1'b0, '0, lfps_pkg::MARKER_LEFT);
    send_frame(1'b1, err_t'(100), lfps_pkg::MARKER_LEFT);
    for (int i = 0; i < 4; i++) send_frame(1'b1, err_t'(-50), lfps_pkg::MARKER_RIGHT);
    send_frame(1'b1, ERR_MAX, lfps_pkg::MARKER_RIGHT);
    send_frame(1'b1, err_t'(300), lfps_pkg::MARKER_UTURN);
    send_frame(1'b1, '0, lfps_pkg::MARKER_NONE);
    send_frame(1'b1, ERR_MIN, lfps_pkg::MARKER_LEFT);
    send_frame(1'b1, err_t'(1), lfps_pkg::MARKER_UTURN);

    // all registers at their maximum, with a left run past counter saturation
    c.prop_gain       = '1;
    c.deriv_gain      = '1;
    c.base_speed      = lfps_pkg::SPEED_MAX;
    c.debounce_frames = '1;
    c.turn_bias       = '1;
    c.max_offset      = '1;
    program_regs(c);
    frame_gaps = 1'b0;
    speed_gaps = 1'b0;
    for (int i = 0; i < 270; i++) send_frame(1'b1, draw_error(), lfps_pkg::MARKER_LEFT);
    send_frame(1'b1, ERR_MAX, lfps_pkg::MARKER_RIGHT);
    run_random_frames(40);

    // all registers at their minimum, debounce of zero, base below the speed range
    c.prop_gain       = '0;
    c.deriv_gain      = '0;
    c.base_speed      = spd_t'(-(1 << (lfps_pkg::SPEED_WIDTH - 1)));
    c.debounce_frames = '0;
    c.turn_bias       = '0;
    c.max_offset      = '0;
    program_regs(c);
    frame_gaps = 1'b1;
    speed_gaps = 1'b1;
    run_random_frames(100);

    // back-pressure: receiver holds off while frames keep coming
    program_regs(draw_cfg());
    frame_gaps = 1'b0;
    speed_gaps = 1'b0;
    hold_go    = 1'b1;
    run_random_frames(PHASE_ITEMS);

    // random settings with random idling on each side
    for (int ph = 0; ph < 8; ph++) begin
      program_regs(draw_cfg());
      frame_gaps = (ph % 4) != 0 && $urandom_range(0, 1);
      speed_gaps = (ph % 4) != 0 && $urandom_range(0, 1);
      run_random_frames(PHASE_ITEMS);
    end

    drain_results();
    $display("run covered %0d frame transactions over %0d register settings",
             frames_sent, settings_used);
    $display("compared %0d speed transactions, %0d failures", sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lfps_pkg.sv
hdl/lfps_if.sv
hdl/lfps_cfg.sv
hdl/lfps_err.sv
hdl/lfps_speed.sv
hdl/line_follow_pd_steering_core.sv
tb/sv/tb.sv
